[hw/rtl/rpg_pkg.sv]
// Package for the raster primitive generator.
// Holds the item, pixel and configuration types and the setup functions for
// lines, rectangle sides and circle spans and points. It depends on nothing.
`default_nettype none

package rpg_pkg;

  localparam int CoordBits   = 8;
  localparam int SizeBits    = CoordBits + 1;
  localparam int ErrBits     = CoordBits + 3;
  localparam int CircBits    = CoordBits + 2;
  localparam int CircErrBits = CoordBits + 4;
  localparam int ColorBits   = 8;

  typedef logic [CoordBits-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_RECT    = 2'd1,
    KIND_CIRC    = 2'd2,
    KIND_ADVANCE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_FILL_MODE     = 2'd0,
    CFG_PIXEL_COLOR   = 2'd1,
    CFG_SCREEN_WIDTH  = 2'd2,
    CFG_SCREEN_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    kind_e  kind;
    coord_t x_a;
    coord_t y_a;
    coord_t x_b;
    coord_t y_b;
    coord_t circle_radius;
  } item_t;

  typedef struct packed {
    coord_t               pixel_x;
    coord_t               pixel_y;
    logic [ColorBits-1:0] pixel_value;
    logic                 last_pixel;
  } pixel_t;

  typedef struct packed {
    logic                 fill_mode;
    logic [ColorBits-1:0] pixel_color;
    logic [SizeBits-1:0]  screen_width;
    logic [SizeBits-1:0]  screen_height;
  } cfg_t;

  // Bresenham line state: cursor, end point, deltas, step directions, error
  typedef struct packed {
    coord_t                    x;
    coord_t                    y;
    coord_t                    ex;
    coord_t                    ey;
    coord_t                    dx;
    coord_t                    dy;
    logic                      sx;
    logic                      sy;
    logic signed [ErrBits-1:0] err;
  } line_t;

  function automatic line_t line_begin(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
    line_t l;
    l.sx = (x2 > x1);
    l.dx = l.sx ? (x2 - x1) : (x1 - x2);
    l.sy = (y2 > y1);
    l.dy = l.sy ? (y2 - y1) : (y1 - y2);
    if (l.dx > l.dy) begin
      l.err = ErrBits'(l.dx >> 1);
    end else begin
      l.err = -ErrBits'(l.dy >> 1);
    end
    l.x  = x1;
    l.y  = y1;
    l.ex = x2;
    l.ey = y2;
    return l;
  endfunction

  function automatic line_t rect_side(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                                      logic [1:0] side);
    line_t l;
    case (side)
      2'd0:    l = line_begin(x1, y1, x2, y1);
      2'd1:    l = line_begin(x1, y2, x2, y2);
      2'd2:    l = line_begin(x1, y1, x1, y2);
      default: l = line_begin(x2, y1, x2, y2);
    endcase
    return l;
  endfunction

  function automatic line_t circ_span(coord_t cx, coord_t cy, coord_t a, coord_t b,
                                      logic [1:0] span);
    line_t l;
    case (span)
      2'd0:    l = line_begin(cx - a, cy + b, cx + a, cy + b);
      2'd1:    l = line_begin(cx - a, cy - b, cx + a, cy - b);
      2'd2:    l = line_begin(cx - b, cy + a, cx + b, cy + a);
      default: l = line_begin(cx - b, cy - a, cx + b, cy - a);
    endcase
    return l;
  endfunction

  // One of the eight symmetric points, packed as {x, y}
  function automatic logic [2*CoordBits-1:0] circ_point(coord_t cx, coord_t cy, coord_t a,
                                                        coord_t b, logic [2:0] k);
    logic [2*CoordBits-1:0] p;
    case (k)
      3'd0:    p = {cx + a, cy + b};
      3'd1:    p = {cx + b, cy + a};
      3'd2:    p = {cx - a, cy + b};
      3'd3:    p = {cx - b, cy + a};
      3'd4:    p = {cx + b, cy - a};
      3'd5:    p = {cx + a, cy - b};
      3'd6:    p = {cx - a, cy - b};
      default: p = {cx - b, cy - a};
    endcase
    return p;
  endfunction

  // Keep the circle centre on screen
  function automatic coord_t clamp_centre(coord_t c, coord_t r, logic [SizeBits-1:0] size);
    logic signed [CoordBits+2:0] room;
    logic [SizeBits-1:0]         far;
    room = $signed({2'b00, size}) - $signed((CoordBits+3)'(1)) - $signed({3'b000, c});
    far  = size - SizeBits'(1) - {1'b0, r};
    if (c < r) begin
      return r;
    end else if (room < $signed({3'b000, r})) begin
      return far[CoordBits-1:0];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rpg_core.sv]
// Primitive sequencer: line, rectangle and circle state, one pixel per advance.
// Uses rpg_pkg for types and the setup functions.
`default_nettype none

module rpg_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_fire_i,
  input  rpg_pkg::item_t     item_i,
  input  rpg_pkg::cfg_t      cfg_i,
  output logic               res_valid_o,
  output rpg_pkg::pixel_t    res_o
);

  typedef enum logic [1:0] {
    SH_IDLE = 2'd0,
    SH_LINE = 2'd1,
    SH_RECT = 2'd2,
    SH_CIRC = 2'd3
  } shape_e;

  localparam int CB  = rpg_pkg::CoordBits;
  localparam int CIB = rpg_pkg::CircBits;
  localparam int CEB = rpg_pkg::CircErrBits;
  localparam int EB  = rpg_pkg::ErrBits;

  shape_e                 shape_q, shape_d;
  logic                   fill_q, fill_d;
  rpg_pkg::line_t         line_q, line_d;
  rpg_pkg::coord_t        ox1_q, ox1_d, oy1_q, oy1_d, ox2_q, ox2_d, oy2_q, oy2_d;
  rpg_pkg::coord_t        orow_q, orow_d;
  logic signed [CIB-1:0]  ca_q, ca_d, cb_q, cb_d;
  logic signed [CEB-1:0]  cerr_q, cerr_d;
  logic [2:0]             sub_q, sub_d;

  // Line step terms
  logic                   at_end, xstep, ystep;
  logic signed [EB-1:0]   dxs, dys, err_n;
  // Circle step terms
  logic signed [CIB-1:0]  ca_n, cb_n;
  logic signed [CEB-1:0]  cerr_n;
  logic                   circ_more;
  // Start terms
  rpg_pkg::coord_t        ymin, ymax, cx, cy;
  rpg_pkg::coord_t        px, py;
  logic [2*CB-1:0]        pt;
  logic                   more;

  always_comb begin
    at_end = (line_q.x == line_q.ex) && (line_q.y == line_q.ey);
    dxs    = $signed(EB'(line_q.dx));
    dys    = $signed(EB'(line_q.dy));
    xstep  = line_q.err > -dxs;
    ystep  = line_q.err < dys;
    err_n  = line_q.err - (xstep ? dys : '0) + (ystep ? dxs : '0);
  end

  // Midpoint step
  always_comb begin
    ca_n = ca_q + CIB'(1);
    if (cerr_q < 0) begin
      cerr_n = cerr_q + CEB'(3) + (CEB'(ca_q) <<< 1);
      cb_n   = cb_q;
    end else begin
      cerr_n = cerr_q + CEB'(5) + ((CEB'(ca_q) - CEB'(cb_q)) <<< 1);
      cb_n   = cb_q - CIB'(1);
    end
    circ_more = ca_n <= cb_n;
  end

  always_comb begin
    ymin = (item_i.y_a < item_i.y_b) ? item_i.y_a : item_i.y_b;
    ymax = (oy1_q < oy2_q) ? oy2_q : oy1_q;
    cx   = rpg_pkg::clamp_centre(item_i.x_a, item_i.circle_radius, cfg_i.screen_width);
    cy   = rpg_pkg::clamp_centre(item_i.y_a, item_i.circle_radius, cfg_i.screen_height);
    pt   = rpg_pkg::circ_point(ox1_q, oy1_q, ca_q[CB-1:0], cb_q[CB-1:0], sub_q);
  end

  // Next state and result for one transfer
  always_comb begin
    shape_d = shape_q;
    fill_d  = fill_q;
    line_d  = line_q;
    ox1_d   = ox1_q;
    oy1_d   = oy1_q;
    ox2_d   = ox2_q;
    oy2_d   = oy2_q;
    orow_d  = orow_q;
    ca_d    = ca_q;
    cb_d    = cb_q;
    cerr_d  = cerr_q;
    sub_d   = sub_q;
    more    = 1'b1;
    px      = line_q.x;
    py      = line_q.y;
    res_valid_o = 1'b0;
    if (in_fire_i) begin
      if (item_i.kind != rpg_pkg::KIND_ADVANCE) begin
        if (shape_q == SH_IDLE) begin
          fill_d = cfg_i.fill_mode;
          sub_d  = '0;
          case (item_i.kind)
            rpg_pkg::KIND_LINE: begin
              line_d  = rpg_pkg::line_begin(item_i.x_a, item_i.y_a, item_i.x_b, item_i.y_b);
              shape_d = SH_LINE;
            end
            rpg_pkg::KIND_RECT: begin
              ox1_d  = item_i.x_a;
              oy1_d  = item_i.y_a;
              ox2_d  = item_i.x_b;
              oy2_d  = item_i.y_b;
              orow_d = ymin;
              if (cfg_i.fill_mode) begin
                line_d = rpg_pkg::line_begin(item_i.x_a, ymin, item_i.x_b, ymin);
              end else begin
                line_d = rpg_pkg::line_begin(item_i.x_a, item_i.y_a, item_i.x_b, item_i.y_a);
              end
              shape_d = SH_RECT;
            end
            default: begin
              ox1_d  = cx;
              oy1_d  = cy;
              ca_d   = '0;
              cb_d   = $signed(CIB'(item_i.circle_radius));
              cerr_d = CEB'(1) - CEB'(item_i.circle_radius);
              line_d = rpg_pkg::circ_span(cx, cy, '0, item_i.circle_radius, 2'd0);
              shape_d = SH_CIRC;
            end
          endcase
        end
      end else if (shape_q != SH_IDLE) begin
        res_valid_o = 1'b1;
        if (shape_q == SH_CIRC && !fill_q) begin
          // Outline circle: eight symmetric points per step
          px = pt[2*CB-1:CB];
          py = pt[CB-1:0];
          if (sub_q == 3'd7) begin
            sub_d  = '0;
            ca_d   = ca_n;
            cb_d   = cb_n;
            cerr_d = cerr_n;
            more   = circ_more;
          end else begin
            sub_d = sub_q + 3'd1;
          end
        end else if (!at_end) begin
          line_d.err = err_n;
          if (xstep) line_d.x = line_q.sx ? line_q.x + CB'(1) : line_q.x - CB'(1);
          if (ystep) line_d.y = line_q.sy ? line_q.y + CB'(1) : line_q.y - CB'(1);
        end else begin
          case (shape_q)
            SH_LINE: more = 1'b0;
            SH_RECT: begin
              if (fill_q) begin
                if (orow_q >= ymax) begin
                  more = 1'b0;
                end else begin
                  orow_d = orow_q + CB'(1);
                  line_d = rpg_pkg::line_begin(ox1_q, orow_q + CB'(1), ox2_q,
                                               orow_q + CB'(1));
                end
              end else if (sub_q >= 3'd3) begin
                more = 1'b0;
              end else begin
                sub_d  = sub_q + 3'd1;
                line_d = rpg_pkg::rect_side(ox1_q, oy1_q, ox2_q, oy2_q, sub_q[1:0] + 2'd1);
              end
            end
            default: begin
              // Filled circle: next span, or next midpoint step after four
              if (sub_q[1:0] == 2'd3) begin
                sub_d  = '0;
                ca_d   = ca_n;
                cb_d   = cb_n;
                cerr_d = cerr_n;
                more   = circ_more;
                line_d = rpg_pkg::circ_span(ox1_q, oy1_q, ca_n[CB-1:0], cb_n[CB-1:0], 2'd0);
              end else begin
                sub_d  = sub_q + 3'd1;
                line_d = rpg_pkg::circ_span(ox1_q, oy1_q, ca_q[CB-1:0], cb_q[CB-1:0],
                                            sub_q[1:0] + 2'd1);
              end
            end
          endcase
        end
        if (!more) begin
          shape_d = SH_IDLE;
          sub_d   = '0;
        end
      end
    end
    res_o.pixel_x     = px;
    res_o.pixel_y     = py;
    res_o.pixel_value = cfg_i.pixel_color;
    res_o.last_pixel  = !more;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SH_IDLE;
      fill_q  <= 1'b0;
      sub_q   <= '0;
      line_q  <= '0;
      ox1_q   <= '0;
      oy1_q   <= '0;
      ox2_q   <= '0;
      oy2_q   <= '0;
      orow_q  <= '0;
      ca_q    <= '0;
      cb_q    <= '0;
      cerr_q  <= '0;
    end else begin
      shape_q <= shape_d;
      fill_q  <= fill_d;
      sub_q   <= sub_d;
      line_q  <= line_d;
      ox1_q   <= ox1_d;
      oy1_q   <= oy1_d;
      ox2_q   <= ox2_d;
      oy2_q   <= oy2_d;
      orow_q  <= orow_d;
      ca_q    <= ca_d;
      cb_q    <= cb_d;
      cerr_q  <= cerr_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/raster_primitive_generator_unit.sv]
// A pixel appears in the output register in the cycle after its advance transfer. One
// item per cycle unless a held, untaken pixel stalls the input; each advance is worked
// out in a single pass of the sequencer in rpg_core and lands in the output register.
// Reset clears the shape state to idle, empties the output register and loads the
// configuration defaults (outline, color 1, screen 128 by 64).
// Depends on rpg_pkg and rpg_core.
`default_nettype none

module raster_primitive_generator_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  rpg_pkg::item_t                    in_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output rpg_pkg::pixel_t                   out_pixel_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [rpg_pkg::SizeBits-1:0] cfg_wdata_i
);

  rpg_pkg::cfg_t   cfg_q;
  logic            out_valid_q, out_valid_d;
  rpg_pkg::pixel_t out_pixel_q, out_pixel_d;
  logic            in_fire, res_valid;
  rpg_pkg::pixel_t res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  rpg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .item_i      (in_item_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Load the output register on a transfer, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_pixel_d = out_pixel_q;
    if (in_fire) begin
      out_valid_d = res_valid;
      out_pixel_d = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pixel_q <= out_pixel_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_mode     <= 1'b0;
      cfg_q.pixel_color   <= rpg_pkg::ColorBits'(1);
      cfg_q.screen_width  <= rpg_pkg::SizeBits'(128);
      cfg_q.screen_height <= rpg_pkg::SizeBits'(64);
    end else if (cfg_we_i) begin
      case (rpg_pkg::cfg_idx_e'(cfg_idx_i))
        rpg_pkg::CFG_FILL_MODE:    cfg_q.fill_mode     <= cfg_wdata_i[0];
        rpg_pkg::CFG_PIXEL_COLOR:  cfg_q.pixel_color   <= cfg_wdata_i[rpg_pkg::ColorBits-1:0];
        rpg_pkg::CFG_SCREEN_WIDTH: cfg_q.screen_width  <= cfg_wdata_i;
        default:                   cfg_q.screen_height <= cfg_wdata_i;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;

endmodule

`default_nettype wire

[hw/rtl/rpg_checker.sv]
// Port checker for raster_primitive_generator_unit, bound to the top level.
// Depends on rpg_pkg.
`default_nettype none

module rpg_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_o,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input rpg_pkg::pixel_t      out_pixel_o
);

  // A held pixel stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("pixel dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_pixel_o))
    else $error("pixel changed while stalled");

  // A new pixel only follows an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("pixel without input transfer");

  // An empty output never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind raster_primitive_generator_unit rpg_checker u_rpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_pixel_o (out_pixel_o)
);

`default_nettype wire

[tb/tb_raster_primitive_generator_unit.sv]
// Testbench for raster_primitive_generator_unit: drives lines, rectangles and circles
// through the valid/ready item port and checks every pixel against an in-bench predictor.
// Depends on rpg_pkg and the unit itself.
`default_nettype none

module tb_raster_primitive_generator_unit;

  localparam int CycleLimit = 1500000;
  localparam int ShIdle = 0, ShLine = 1, ShRect = 2, ShCirc = 3;

  logic clk, rst_n;
  logic in_valid, out_ready, cfg_we;
  rpg_pkg::item_t in_item;
  logic out_valid, in_ready;
  rpg_pkg::pixel_t out_pixel;
  logic [1:0] cfg_idx;
  logic [rpg_pkg::SizeBits-1:0] cfg_wdata;

  raster_primitive_generator_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_pixel_o(out_pixel),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  // Register copy and drawing state of the predictor
  int cf_fill, cf_color, cf_w, cf_h;
  int shape, fill_held, part;
  int lx, ly, lex, ley, ldx, ldy, lsx, lsy, lerr;
  int ox1, oy1, ox2, oy2, orow, oymax;
  int ca, cb, cerr;

  rpg_pkg::pixel_t pixels_due[$];
  int errors, cycles, sent, burst_left, hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_raster_primitive_generator_unit: errors");
      $finish;
    end
  end

  function automatic int m8(int v);
    return v & 255;
  endfunction

  function void line_start(int x1, int y1, int x2, int y2);
    x1 = m8(x1); y1 = m8(y1); x2 = m8(x2); y2 = m8(y2);
    if (x2 > x1) begin ldx = x2 - x1; lsx = 1; end else begin ldx = x1 - x2; lsx = 255; end
    if (y2 > y1) begin ldy = y2 - y1; lsy = 1; end else begin ldy = y1 - y2; lsy = 255; end
    lerr = (ldx > ldy) ? ldx / 2 : -(ldy / 2);
    lx = x1; ly = y1; lex = x2; ley = y2;
  endfunction

  // Step the cursor; zero when it already sat on the end point
  function int line_step();
    int e0;
    e0 = lerr;
    if (lx == lex && ly == ley) return 0;
    if (e0 > -ldx) begin lerr -= ldy; lx = m8(lx + lsx); end
    if (e0 < ldy) begin lerr += ldx; ly = m8(ly + lsy); end
    return 1;
  endfunction

  function void side_start(int s);
    case (s)
      0: line_start(ox1, oy1, ox2, oy1);
      1: line_start(ox1, oy2, ox2, oy2);
      2: line_start(ox1, oy1, ox1, oy2);
      default: line_start(ox2, oy1, ox2, oy2);
    endcase
  endfunction

  function void span_start(int s);
    case (s)
      0: line_start(ox1 - ca, oy1 + cb, ox1 + ca, oy1 + cb);
      1: line_start(ox1 - ca, oy1 - cb, ox1 + ca, oy1 - cb);
      2: line_start(ox1 - cb, oy1 + ca, ox1 + cb, oy1 + ca);
      default: line_start(ox1 - cb, oy1 - ca, ox1 + cb, oy1 - ca);
    endcase
  endfunction

  function int mid_step();
    if (cerr < 0) begin
      cerr += 3 + 2 * ca; ca++;
    end else begin
      cerr += 5 + 2 * (ca - cb); ca++; cb--;
    end
    return ca <= cb;
  endfunction

  function automatic int centre_fix(int c, int r, int size);
    if (c < r) return r;
    if (size - 1 - c < r) return m8(size - 1 - r);
    return c;
  endfunction

  // Advance the predictor by one transferred item and queue any pixel it yields
  function void predict_pixel(rpg_pkg::item_t it);
    int px, py, more;
    rpg_pkg::pixel_t p;
    more = 1;
    if (it.kind != rpg_pkg::KIND_ADVANCE) begin
      if (shape != ShIdle) return;
      fill_held = cf_fill;
      part = 0;
      if (it.kind == rpg_pkg::KIND_LINE) begin
        line_start(it.x_a, it.y_a, it.x_b, it.y_b);
        shape = ShLine;
      end else if (it.kind == rpg_pkg::KIND_RECT) begin
        ox1 = it.x_a; oy1 = it.y_a; ox2 = it.x_b; oy2 = it.y_b;
        if (fill_held) begin
          orow = (oy1 < oy2) ? oy1 : oy2;
          oymax = (oy1 < oy2) ? oy2 : oy1;
          line_start(ox1, orow, ox2, orow);
        end else begin
          side_start(0);
        end
        shape = ShRect;
      end else begin
        ox1 = centre_fix(it.x_a, it.circle_radius, cf_w);
        oy1 = centre_fix(it.y_a, it.circle_radius, cf_h);
        ca = 0; cb = it.circle_radius; cerr = 1 - cb;
        if (fill_held) span_start(0);
        shape = ShCirc;
      end
      return;
    end
    if (shape == ShIdle) return;
    if (shape == ShCirc && !fill_held) begin
      case (part)
        0: begin px = ox1 + ca; py = oy1 + cb; end
        1: begin px = ox1 + cb; py = oy1 + ca; end
        2: begin px = ox1 - ca; py = oy1 + cb; end
        3: begin px = ox1 - cb; py = oy1 + ca; end
        4: begin px = ox1 + cb; py = oy1 - ca; end
        5: begin px = ox1 + ca; py = oy1 - cb; end
        6: begin px = ox1 - ca; py = oy1 - cb; end
        default: begin px = ox1 - cb; py = oy1 - ca; end
      endcase
      part++;
      if (part >= 8) begin part = 0; more = mid_step(); end
    end else begin
      px = lx; py = ly;
      if (!line_step()) begin
        if (shape == ShLine) begin
          more = 0;
        end else if (shape == ShRect) begin
          if (fill_held) begin
            if (orow >= oymax) more = 0;
            else begin orow++; line_start(ox1, orow, ox2, orow); end
          end else if (part >= 3) begin
            more = 0;
          end else begin
            part++; side_start(part);
          end
        end else begin
          part++;
          if (part >= 4) begin part = 0; more = mid_step(); end
          if (more) span_start(part);
        end
      end
    end
    if (!more) begin shape = ShIdle; part = 0; end
    p.pixel_x = rpg_pkg::CoordBits'(m8(px));
    p.pixel_y = rpg_pkg::CoordBits'(m8(py));
    p.pixel_value = cf_color[7:0];
    p.last_pixel = (more == 0);
    pixels_due.push_back(p);
  endfunction

  // Receiver: stall patterns in stretches, plus a long hold on request
  int hold_cnt, rx_mode, rx_left;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(5, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Compare each pixel transfer with the oldest expected pixel
  always @(posedge clk) begin
    rpg_pkg::pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel x=%0d y=%0d", out_pixel.pixel_x,
                                   out_pixel.pixel_y);
      end else begin
        want = pixels_due.pop_front();
        if (out_pixel !== want) begin
          errors++;
          if (errors <= 10)
            $display("pixel mismatch: want %0d,%0d v=%0d l=%0b got %0d,%0d v=%0d l=%0b",
                     want.pixel_x, want.pixel_y, want.pixel_value, want.last_pixel,
                     out_pixel.pixel_x, out_pixel.pixel_y, out_pixel.pixel_value,
                     out_pixel.last_pixel);
        end
      end
    end
  end

  // Send one item in bursts with random gaps; predict once it transfers
  task automatic send_item(rpg_pkg::kind_e k, int xa, int ya, int xb, int yb, int r);
    rpg_pkg::item_t it;
    it.kind = k;
    it.x_a = rpg_pkg::CoordBits'(xa);
    it.y_a = rpg_pkg::CoordBits'(ya);
    it.x_b = rpg_pkg::CoordBits'(xb);
    it.y_b = rpg_pkg::CoordBits'(yb);
    it.circle_radius = rpg_pkg::CoordBits'(r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predict_pixel(it);
    sent++;
  endtask

  // Draw one whole primitive: a start, then advances until the last pixel
  task automatic draw(rpg_pkg::kind_e k, int xa, int ya, int xb, int yb, int r);
    send_item(k, xa, ya, xb, yb, r);
    while (shape != ShIdle) send_item(rpg_pkg::KIND_ADVANCE, $urandom, $urandom, $urandom,
                                      $urandom, $urandom);
  endtask

  // Hold off until every pixel is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(rpg_pkg::cfg_idx_e idx, int val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= rpg_pkg::SizeBits'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rpg_pkg::CFG_FILL_MODE: cf_fill = val & 1;
      rpg_pkg::CFG_PIXEL_COLOR: cf_color = val & 255;
      rpg_pkg::CFG_SCREEN_WIDTH: cf_w = val & 511;
      default: cf_h = val & 511;
    endcase
  endtask

  task automatic test_lines();
    draw(rpg_pkg::KIND_LINE, 0, 0, 40, 40, 0);
    draw(rpg_pkg::KIND_LINE, 255, 0, 215, 40, 255);
    draw(rpg_pkg::KIND_LINE, 7, 9, 7, 9, 0);
    draw(rpg_pkg::KIND_LINE, 10, 200, 90, 170, 3);
    draw(rpg_pkg::KIND_LINE, 250, 5, 200, 40, 0);
  endtask

  task automatic test_rects();
    drain();
    write_reg(rpg_pkg::CFG_PIXEL_COLOR, 255);
    draw(rpg_pkg::KIND_RECT, 10, 20, 4, 15, 0);
    draw(rpg_pkg::KIND_RECT, 255, 255, 250, 250, 0);
    drain();
    write_reg(rpg_pkg::CFG_FILL_MODE, 1);
    write_reg(rpg_pkg::CFG_PIXEL_COLOR, 0);
    draw(rpg_pkg::KIND_RECT, 5, 250, 5, 255, 0);
    draw(rpg_pkg::KIND_RECT, 30, 8, 20, 3, 0);
    drain();
  endtask

  task automatic test_circles();
    draw(rpg_pkg::KIND_CIRC, 40, 30, 0, 0, 0);
    draw(rpg_pkg::KIND_CIRC, 0, 255, 0, 0, 6);
    drain();
    write_reg(rpg_pkg::CFG_FILL_MODE, 0);
    write_reg(rpg_pkg::CFG_SCREEN_WIDTH, 256);
    write_reg(rpg_pkg::CFG_SCREEN_HEIGHT, 1);
    draw(rpg_pkg::KIND_CIRC, 100, 100, 0, 0, 0);
    draw(rpg_pkg::KIND_CIRC, 255, 0, 0, 0, 20);
    drain();
    write_reg(rpg_pkg::CFG_SCREEN_WIDTH, 0);
    write_reg(rpg_pkg::CFG_SCREEN_HEIGHT, 511);
    draw(rpg_pkg::KIND_CIRC, 200, 3, 0, 0, 9);
    drain();
  endtask

  // Starts while busy and advances while idle must be dropped
  task automatic test_ignored_items();
    send_item(rpg_pkg::KIND_ADVANCE, 1, 2, 3, 4, 5);
    send_item(rpg_pkg::KIND_LINE, 0, 0, 20, 5, 0);
    send_item(rpg_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0);
    send_item(rpg_pkg::KIND_CIRC, 50, 50, 0, 0, 10);
    send_item(rpg_pkg::KIND_RECT, 1, 1, 9, 9, 0);
    while (shape != ShIdle) send_item(rpg_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0);
    send_item(rpg_pkg::KIND_ADVANCE, 255, 255, 255, 255, 255);
  endtask

  // Stall the output long enough to back up the input, then drain fully
  task automatic test_backpressure();
    hold_req = 1;
    draw(rpg_pkg::KIND_LINE, 0, 0, 60, 17, 0);
    drain();
  endtask

  task automatic test_random();
    int n, k, xa, ya, w, h, r, next_cfg;
    n = 0;
    next_cfg = 0;
    while (n < 330) begin
      if (n >= next_cfg) begin
        next_cfg = n + 110;
        drain();
        write_reg(rpg_pkg::CFG_FILL_MODE, $urandom);
        write_reg(rpg_pkg::CFG_PIXEL_COLOR, $urandom);
        write_reg(rpg_pkg::CFG_SCREEN_WIDTH, ($urandom_range(0, 3) == 0) ?
                  $urandom_range(0, 511) : $urandom_range(1, 256));
        write_reg(rpg_pkg::CFG_SCREEN_HEIGHT, ($urandom_range(0, 3) == 0) ?
                  $urandom_range(0, 511) : $urandom_range(1, 256));
      end
      k = $urandom_range(0, 9);
      xa = $urandom_range(0, 255); ya = $urandom_range(0, 255);
      if (k == 0) begin
        // Noise: any item, whether or not the block is busy
        send_item(rpg_pkg::kind_e'($urandom_range(0, 3)), xa, ya, $urandom, $urandom,
                  $urandom_range(0, 12));
        n++;
      end else begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 10);
        h = $urandom_range(0, 10);
        r = ($urandom_range(0, 19) == 0 && !cf_fill) ? $urandom_range(0, 255) :
            $urandom_range(0, 8);
        case (k % 3)
          0: send_item(rpg_pkg::KIND_LINE, xa, ya, $urandom, $urandom, $urandom);
          1: send_item(rpg_pkg::KIND_RECT, xa, ya, xa + (($urandom & 1) ? w : -w),
                       ya + (($urandom & 1) ? h : -h), $urandom);
          default: send_item(rpg_pkg::KIND_CIRC, xa, ya, $urandom, $urandom, r);
        endcase
        n++;
        while (shape != ShIdle) begin
          if ($urandom_range(0, 40) == 0)
            send_item(rpg_pkg::kind_e'($urandom_range(0, 2)), $urandom, $urandom, $urandom,
                      $urandom, $urandom);
          else
            send_item(rpg_pkg::KIND_ADVANCE, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
          n++;
        end
      end
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_item = '0; cfg_we = 1'b0; cfg_idx = '0;
    cfg_wdata = '0; out_ready = 1'b0;
    errors = 0; cycles = 0; sent = 0; burst_left = 0; hold_req = 0;
    hold_cnt = 0; rx_mode = 0; rx_left = 0;
    cf_fill = 0; cf_color = 1; cf_w = 128; cf_h = 64;
    shape = ShIdle; part = 0; fill_held = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_lines();
    test_rects();
    test_circles();
    test_ignored_items();
    test_backpressure();
    test_random();
    repeat (10) @(posedge clk);
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("tb_raster_primitive_generator_unit: clean");
    end else begin
      $display("tb_raster_primitive_generator_unit: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
